// ===== sv/knrb_pkg.sv =====
// Shared types, constants and codes for the keyed node register bank.
`timescale 1ns / 1ps
package knrb_pkg;

   localparam int ENTRIES    = 8;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int CODE_W     = 8;
   localparam int VALUE_W    = 32;
   localparam int FLAGS_W    = 8;
   localparam int CAPS_W     = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int QUEUE_DEPTH = 2;

   // register indexes
   localparam logic [0:0] REG_CAPABILITY_CODES = 1'b0;

   // command kinds
   localparam logic [1:0] REQ_READ    = 2'd0;
   localparam logic [1:0] REQ_WRITE   = 2'd1;
   localparam logic [1:0] REQ_LIST    = 2'd2;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_UNKNOWN   = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic               hit;
      logic [IDX_W-1:0]   idx;
      logic [VALUE_W-1:0] wdata;
      logic               ack;
      logic [CNT_W-1:0]   count;
   } cmd_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [VALUE_W-1:0] read_value;
      logic [CODE_W-1:0]  cap_code;
      logic [FLAGS_W-1:0] change_flags;
      logic               last;
   } rsp_type;

endpackage

// ===== sv/knrb_front.sv =====
// Front end: accepts commands, looks up the function code, queues classified commands.
`timescale 1ns / 1ps
module knrb_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [knrb_pkg::CAPS_W-1:0] caps,
   input  logic                        push,
   output logic                        full,
   input  logic [1:0]                  req_type,
   input  logic [knrb_pkg::CODE_W-1:0] req_function_code,
   input  logic [knrb_pkg::VALUE_W-1:0] req_write_value,
   input  logic                        req_ack_changes,
   output logic                        cmd_valid,
   output knrb_pkg::cmd_type           cmd_head,
   input  logic                        cmd_pop
);

   localparam int PTR_W = $clog2(knrb_pkg::QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(knrb_pkg::QUEUE_DEPTH + 1);

   knrb_pkg::cmd_type                  cmd_new;
   logic [knrb_pkg::ENTRIES-1:0]       live;
   knrb_pkg::cmd_type                  queue_ff [knrb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]                   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]                  count_ff, count_in;
   logic                               do_push, do_pop;

   // the list runs up to the first zero code
   always_comb begin
      logic                        alive;
      logic [knrb_pkg::CODE_W-1:0] code_i;
      alive   = 1'b1;
      cmd_new = '0;
      live    = '0;
      for (int i = 0; i < knrb_pkg::ENTRIES; i++) begin
         code_i  = caps[i*knrb_pkg::CODE_W +: knrb_pkg::CODE_W];
         alive   = alive & (code_i != '0);
         live[i] = alive;
         cmd_new.count = cmd_new.count + knrb_pkg::CNT_W'(alive);
      end
      // scan downward so the first match wins
      for (int i = knrb_pkg::ENTRIES - 1; i >= 0; i--) begin
         if (live[i] &&
             caps[i*knrb_pkg::CODE_W +: knrb_pkg::CODE_W] == req_function_code) begin
            cmd_new.hit = 1'b1;
            cmd_new.idx = knrb_pkg::IDX_W'(i);
         end
      end
      cmd_new.kind  = req_type;
      cmd_new.wdata = req_write_value;
      cmd_new.ack   = req_ack_changes;
   end

   assign full      = (count_ff == QCNT_W'(knrb_pkg::QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_head  = queue_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(do_push);
      rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== sv/knrb_back.sv =====
// Back end: executes queued commands against the value bank and queues the results.
`timescale 1ns / 1ps
module knrb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [knrb_pkg::CAPS_W-1:0] caps,
   input  logic                        cmd_valid,
   input  knrb_pkg::cmd_type           cmd_head,
   output logic                        cmd_pop,
   output logic                        empty,
   input  logic                        pop,
   output knrb_pkg::rsp_type           rsp_head
);

   localparam int PTR_W = $clog2(knrb_pkg::QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(knrb_pkg::QUEUE_DEPTH + 1);

   logic [knrb_pkg::VALUE_W-1:0] store_ff [knrb_pkg::ENTRIES];
   logic [knrb_pkg::FLAGS_W-1:0] mask_ff, mask_in;
   logic [knrb_pkg::IDX_W-1:0]   pos_ff, pos_in;
   knrb_pkg::rsp_type            queue_ff [knrb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]            count_ff, count_in;
   logic                         go, do_pop, store_wr, item_done;
   logic [knrb_pkg::VALUE_W-1:0] stored;
   logic [knrb_pkg::FLAGS_W-1:0] flags;
   knrb_pkg::rsp_type            rsp_new;

   assign go       = cmd_valid && (count_ff != QCNT_W'(knrb_pkg::QUEUE_DEPTH));
   assign stored   = store_ff[cmd_head.idx];
   assign store_wr = go && (cmd_head.kind == knrb_pkg::REQ_WRITE) && cmd_head.hit &&
                     (stored != cmd_head.wdata);
   assign flags    = store_wr ? (mask_ff | (knrb_pkg::FLAGS_W'(1) << cmd_head.idx)) : mask_ff;

   always_comb begin
      rsp_new              = '0;
      rsp_new.change_flags = flags;
      rsp_new.last         = 1'b1;
      case (cmd_head.kind)
         knrb_pkg::REQ_READ: begin
            rsp_new.status     = cmd_head.hit ? knrb_pkg::ST_OK : knrb_pkg::ST_NOT_FOUND;
            rsp_new.read_value = cmd_head.hit ? stored : '0;
         end
         knrb_pkg::REQ_WRITE: begin
            rsp_new.status = cmd_head.hit ? knrb_pkg::ST_OK : knrb_pkg::ST_NOT_FOUND;
         end
         knrb_pkg::REQ_LIST: begin
            rsp_new.status = knrb_pkg::ST_OK;
            if (cmd_head.count != '0) begin
               rsp_new.cap_code = caps[pos_ff*knrb_pkg::CODE_W +: knrb_pkg::CODE_W];
               rsp_new.last     = (knrb_pkg::CNT_W'(pos_ff) + knrb_pkg::CNT_W'(1)
                                   == cmd_head.count);
            end
         end
         default: begin
            rsp_new.status = knrb_pkg::ST_UNKNOWN;
         end
      endcase
   end

   assign item_done = go && rsp_new.last;
   assign cmd_pop   = item_done;

   always_comb begin
      // advance through the listing, restart at the next command
      pos_in = pos_ff;
      if (item_done) begin
         pos_in = '0;
      end else if (go) begin
         pos_in = pos_ff + knrb_pkg::IDX_W'(1);
      end
      mask_in = mask_ff;
      if (item_done) begin
         mask_in = cmd_head.ack ? '0 : flags;
      end
   end

   assign empty    = (count_ff == '0);
   assign rsp_head = queue_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(go);
      rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
      count_in  = count_ff + QCNT_W'(go) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         pos_ff    <= '0;
         mask_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         mask_ff   <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < knrb_pkg::ENTRIES; i++) begin
            store_ff[i] <= '0;
         end
      end else if (store_wr) begin
         store_ff[cmd_head.idx] <= cmd_head.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         queue_ff[wr_ptr_ff] <= rsp_new;
      end
   end

endmodule

// ===== sv/keyed_node_register_bank.sv =====
// A command is held in the front queue; its results are registered into the result queue.
// Throughput: one command per cycle enters while not full; the back end emits one result
// per cycle while its result queue has room, so a listing of N codes gives N results, others one.
// Both sides are two-entry queues; full and empty follow their fill levels.
// Reset (synchronous): queues empty, value bank and change flags zero, code list zero.
`timescale 1ns / 1ps
module keyed_node_register_bank (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [1:0]                      req_type,
   input  logic [knrb_pkg::CODE_W-1:0]     req_function_code,
   input  logic [knrb_pkg::VALUE_W-1:0]    req_write_value,
   input  logic                            req_ack_changes,
   output logic                            empty,
   input  logic                            pop,
   output logic [1:0]                      rsp_status,
   output logic [knrb_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic [knrb_pkg::CODE_W-1:0]     rsp_cap_code,
   output logic [knrb_pkg::FLAGS_W-1:0]    rsp_change_flags,
   output logic                            rsp_last,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [knrb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [knrb_pkg::CAPS_W-1:0]     pwdata,
   output logic [knrb_pkg::CAPS_W-1:0]     prdata,
   output logic                            pready
);

   logic [knrb_pkg::CAPS_W-1:0] caps_ff, caps_in;
   logic                        csr_write;
   logic                        cmd_valid, cmd_pop;
   knrb_pkg::cmd_type           cmd_head;
   knrb_pkg::rsp_type           rsp_head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[knrb_pkg::CSR_ADDR_W-1] == knrb_pkg::REG_CAPABILITY_CODES);
   assign caps_in   = csr_write ? pwdata : caps_ff;
   assign prdata    = (paddr[knrb_pkg::CSR_ADDR_W-1] == knrb_pkg::REG_CAPABILITY_CODES) ?
                      caps_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         caps_ff <= '0;
      end else begin
         caps_ff <= caps_in;
      end
   end

   knrb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .caps              (caps_ff),
      .push              (push),
      .full              (full),
      .req_type          (req_type),
      .req_function_code (req_function_code),
      .req_write_value   (req_write_value),
      .req_ack_changes   (req_ack_changes),
      .cmd_valid         (cmd_valid),
      .cmd_head          (cmd_head),
      .cmd_pop           (cmd_pop)
   );

   knrb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .caps      (caps_ff),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_head  (rsp_head)
   );

   assign rsp_status       = rsp_head.status;
   assign rsp_read_value   = rsp_head.read_value;
   assign rsp_cap_code     = rsp_head.cap_code;
   assign rsp_change_flags = rsp_head.change_flags;
   assign rsp_last         = rsp_head.last;

   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_status != 2'd3))
      else $error("result carries an undefined status");

   a_partial_list: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_last) |-> (rsp_status == knrb_pkg::ST_OK) && (rsp_cap_code != '0))
      else $error("non-final result is not a listed capability code");

   a_value_on_hit: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_read_value != '0)) |-> (rsp_status == knrb_pkg::ST_OK) && rsp_last)
      else $error("read value returned without a hit");

endmodule

// ===== dv/knrb_checker.sv =====
// Checker for the keyed node register bank: predicts every result and compares it.
`timescale 1ns / 1ps
module knrb_checker
   import knrb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  full,
   input  logic [1:0]            req_type,
   input  logic [CODE_W-1:0]     req_function_code,
   input  logic [VALUE_W-1:0]    req_write_value,
   input  logic                  req_ack_changes,
   input  logic                  empty,
   input  logic                  pop,
   input  logic [1:0]            rsp_status,
   input  logic [VALUE_W-1:0]    rsp_read_value,
   input  logic [CODE_W-1:0]     rsp_cap_code,
   input  logic [FLAGS_W-1:0]    rsp_change_flags,
   input  logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CAPS_W-1:0]     pwdata,
   input  logic [CAPS_W-1:0]     prdata,
   input  logic                  pready,
   output int unsigned           fail_count,
   output int unsigned           outstanding,
   output int unsigned           commands_seen,
   output int unsigned           results_seen
);

   localparam logic [CSR_ADDR_W-1:0] CAPS_ADDR = {REG_CAPABILITY_CODES, 3'b000};

   logic [CAPS_W-1:0]  code_list;
   logic [VALUE_W-1:0] bank [ENTRIES];
   logic [FLAGS_W-1:0] dirty;
   rsp_type            pending_results [$];

   task automatic log_mismatch(input string what, input logic [CAPS_W-1:0] got,
                               input logic [CAPS_W-1:0] want);
      if (fail_count < 20)
         $display("%0t: mismatch in %s: got %0h, expected %0h (result %0d)",
                  $time, what, got, want, results_seen);
      fail_count++;
   endtask

   // codes up to the first zero, at most ENTRIES of them
   function automatic int unsigned list_size(input logic [CAPS_W-1:0] caps);
      int unsigned n;
      n = 0;
      while (n < ENTRIES && caps[CODE_W*n +: CODE_W] != '0)
         n++;
      return n;
   endfunction

   function automatic int match_slot(input logic [CAPS_W-1:0] caps,
                                     input logic [CODE_W-1:0] code);
      int unsigned n;
      n = list_size(caps);
      for (int i = 0; i < n; i++)
         if (caps[CODE_W*i +: CODE_W] == code)
            return i;
      return -1;
   endfunction

   task automatic predict_command(input logic [1:0] kind, input logic [CODE_W-1:0] code,
                                  input logic [VALUE_W-1:0] wval, input logic ack);
      rsp_type     r;
      int          slot;
      int unsigned n;
      r = '0;
      r.last = 1'b1;
      case (kind)
         REQ_READ: begin
            slot = match_slot(code_list, code);
            if (slot >= 0)
               r.read_value = bank[slot];
            else
               r.status = ST_NOT_FOUND;
            r.change_flags = dirty;
            pending_results.push_back(r);
         end
         REQ_WRITE: begin
            slot = match_slot(code_list, code);
            if (slot >= 0) begin
               // store and flag only when the value really changes
               if (bank[slot] != wval) begin
                  bank[slot] = wval;
                  dirty[slot] = 1'b1;
               end
            end else begin
               r.status = ST_NOT_FOUND;
            end
            r.change_flags = dirty;
            pending_results.push_back(r);
         end
         REQ_LIST: begin
            n = list_size(code_list);
            r.change_flags = dirty;
            if (n == 0) begin
               pending_results.push_back(r);
            end else begin
               for (int i = 0; i < n; i++) begin
                  r.cap_code = code_list[CODE_W*i +: CODE_W];
                  r.last = (i + 1 == n);
                  pending_results.push_back(r);
               end
            end
         end
         default: begin
            r.status = ST_UNKNOWN;
            r.change_flags = dirty;
            pending_results.push_back(r);
         end
      endcase
      if (ack)
         dirty = '0;
   endtask

   task automatic compare_result();
      rsp_type want;
      if (pending_results.size() == 0) begin
         log_mismatch("result with none outstanding", CAPS_W'(rsp_read_value), '0);
      end else begin
         want = pending_results.pop_front();
         if (rsp_status !== want.status)
            log_mismatch("status", CAPS_W'(rsp_status), CAPS_W'(want.status));
         if (rsp_read_value !== want.read_value)
            log_mismatch("read_value", CAPS_W'(rsp_read_value), CAPS_W'(want.read_value));
         if (rsp_cap_code !== want.cap_code)
            log_mismatch("cap_code", CAPS_W'(rsp_cap_code), CAPS_W'(want.cap_code));
         if (rsp_change_flags !== want.change_flags)
            log_mismatch("change_flags", CAPS_W'(rsp_change_flags),
                         CAPS_W'(want.change_flags));
         if (rsp_last !== want.last)
            log_mismatch("last", CAPS_W'(rsp_last), CAPS_W'(want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         code_list = '0;
         dirty = '0;
         for (int i = 0; i < ENTRIES; i++)
            bank[i] = '0;
         pending_results.delete();
         fail_count = 0;
         commands_seen = 0;
         results_seen = 0;
         outstanding <= 0;
      end else begin
         // a result never belongs to the command taken at the same edge
         if (pop && !empty) begin
            compare_result();
            results_seen++;
         end
         if (push && !full) begin
            predict_command(req_type, req_function_code, req_write_value, req_ack_changes);
            commands_seen++;
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == CAPS_ADDR)
                  code_list = pwdata;
            end else if (paddr == CAPS_ADDR && prdata !== code_list) begin
               log_mismatch("capability_codes readback", prdata, code_list);
            end
         end
         outstanding <= pending_results.size();
      end
   end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the keyed node register bank: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps
module tb;
   import knrb_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CAPS_ADDR = {REG_CAPABILITY_CODES, 3'b000};

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [1:0]            req_type = REQ_READ;
   logic [CODE_W-1:0]     req_function_code = '0;
   logic [VALUE_W-1:0]    req_write_value = '0;
   logic                  req_ack_changes = 1'b0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [1:0]            rsp_status;
   logic [VALUE_W-1:0]    rsp_read_value;
   logic [CODE_W-1:0]     rsp_cap_code;
   logic [FLAGS_W-1:0]    rsp_change_flags;
   logic                  rsp_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CAPS_W-1:0]     pwdata = '0;
   logic [CAPS_W-1:0]     prdata;
   logic                  pready;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned commands_seen;
   int unsigned results_seen;

   logic [CAPS_W-1:0] caps_now = '0;
   logic              steady = 1'b0;
   int unsigned       pop_hold = 0;
   int unsigned       settings_used = 1;

   logic [CAPS_W-1:0] code_settings [5] = '{
      64'hFFFF_FFFF_FFFF_FFFF,
      64'h7766_5544_0033_2211,
      64'h0000_0000_0000_0042,
      64'h0000_0000_0000_0000,
      64'h0180_7FFE_2233_44FF
   };

   keyed_node_register_bank i_dut (.*);
   knrb_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // mostly codes taken from the programmed list, plus the zero code (never a match), all-ones and random codes
   function automatic logic [CODE_W-1:0] pick_code();
      int unsigned r;
      int unsigned slot;
      r = $urandom_range(0, 9);
      slot = $urandom_range(0, ENTRIES - 1);
      if (r < 7)
         return caps_now[CODE_W*slot +: CODE_W];
      if (r == 7)
         return '0;
      if (r == 8)
         return '1;
      return CODE_W'($urandom_range(0, 255));
   endfunction

   // small value set so that repeated writes of the same value are common
   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 25)
         return '0;
      if (r < 40)
         return '1;
      if (r < 70)
         return $urandom_range(0, 3);
      return $urandom;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         pop_hold <= 0;
      end else if (steady) begin
         pop <= 1'b1;
      end else if (pop_hold != 0) begin
         pop_hold <= pop_hold - 1;
      end else if ($urandom_range(0, 2) != 0) begin
         pop <= 1'b1;
         pop_hold <= $urandom_range(0, 6);
      end else begin
         pop <= 1'b0;
         pop_hold <= gap_len();
      end
   end

   // returns at the edge where the transaction is taken, push still high
   task automatic issue(input logic [1:0] kind, input logic [CODE_W-1:0] code,
                        input logic [VALUE_W-1:0] value, input logic ack);
      int unsigned idle;
      idle = steady ? 0 : gap_len();
      if (idle != 0) begin
         push <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      push <= 1'b1;
      req_type <= kind;
      req_function_code <= code;
      req_write_value <= value;
      req_ack_changes <= ack;
      @(posedge clock);
      while (full)
         @(posedge clock);
   endtask

   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write the code list, then read it back for the checker
   task automatic program_caps(input logic [CAPS_W-1:0] value);
      drain();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CAPS_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      caps_now = value;
   endtask

   task automatic random_burst(input int unsigned count);
      int unsigned r;
      logic [1:0]  kind;
      repeat (count) begin
         r = $urandom_range(0, 99);
         kind = (r < 35) ? REQ_READ : (r < 70) ? REQ_WRITE : (r < 85) ? REQ_LIST : REQ_UNKNOWN;
         issue(kind, pick_code(), pick_value(), $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty code list straight out of reset
      issue(REQ_READ, 8'h00, '0, 1'b0);
      issue(REQ_LIST, 8'h00, '0, 1'b0);
      issue(REQ_WRITE, 8'h11, '1, 1'b0);
      issue(REQ_UNKNOWN, '1, '1, 1'b1);

      // eight codes: FF, 44, 33, 22, FE, 7F, 80, 01
      program_caps(64'h0180_7FFE_2233_44FF);
      issue(REQ_WRITE, 8'hFF, '1, 1'b0);
      issue(REQ_WRITE, 8'hFF, '1, 1'b0);
      issue(REQ_READ, 8'hFF, '0, 1'b0);
      issue(REQ_WRITE, 8'h01, '0, 1'b0);
      issue(REQ_WRITE, 8'h01, 32'hA5A5_5A5A, 1'b0);
      issue(REQ_READ, 8'h01, '0, 1'b0);
      issue(REQ_READ, 8'h00, '0, 1'b0);
      issue(REQ_READ, 8'h99, '0, 1'b0);
      issue(REQ_WRITE, 8'h99, 32'h1234_5678, 1'b0);
      issue(REQ_LIST, 8'h00, '0, 1'b0);
      issue(REQ_UNKNOWN, 8'h44, '1, 1'b0);
      issue(REQ_READ, 8'h44, '0, 1'b1);
      issue(REQ_READ, 8'h80, '0, 1'b0);
      issue(REQ_LIST, '1, '1, 1'b1);

      foreach (code_settings[k]) begin
         program_caps(k == 4 ? {$urandom, $urandom} : code_settings[k]);
         steady <= (k == 1);
         settings_used++;
         random_burst(20);
      end
      steady <= 1'b0;
      drain();
      repeat (10) @(posedge clock);

      $display("Ran %0d commands over %0d code-list settings, %0d results compared.",
               commands_seen, settings_used, results_seen);
      $display("Covered reads, writes, listings and unknown commands under random stalls.");
      if (fail_count == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
